>>> hdl/gebin_pkg.sv
// types and constants shared by the grid edge binning block
package gebin_pkg;

  localparam int MaxSide = 64;
  localparam int Cells   = MaxSide * MaxSide;
  localparam int CellW   = $clog2(Cells);
  localparam int SideW   = $clog2(MaxSide);
  localparam int PartW   = 7;

  localparam logic [2:0] KindCount    = 3'd0;
  localparam logic [2:0] KindPlace    = 3'd1;
  localparam logic [2:0] KindRead     = 3'd2;
  localparam logic [2:0] KindClrCtr   = 3'd3;
  localparam logic [2:0] KindActivate = 3'd4;
  localparam logic [2:0] KindClrMark  = 3'd5;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatVertex   = 2'd1;
  localparam logic [1:0] StatCell     = 2'd2;
  localparam logic [1:0] StatOverflow = 2'd3;

  localparam logic CfgVertexCount    = 1'b0;
  localparam logic CfgPartitionCount = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] src_vertex;
    logic [31:0] dest_vertex;
    logic [11:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  row_part;
    logic [5:0]  col_part;
    logic [11:0] cell_out;
    logic [31:0] slot;
    logic [31:0] cell_total;
    logic        cell_active;
    logic [6:0]  marked_cells;
  } out_t;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CLR    = 11'b00000000010,
    S_DIV    = 11'b00000000100,
    S_POST   = 11'b00000001000,
    S_VSEL   = 11'b00000010000,
    S_CELL   = 11'b00000100000,
    S_RD     = 11'b00001000000,
    S_RMW    = 11'b00010000000,
    S_ACTRD  = 11'b00100000000,
    S_ACTCHK = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_N   = 2'd0,
    PH_SRC = 2'd1,
    PH_DST = 2'd2,
    PH_REQ = 2'd3
  } phase_e;

endpackage

>>> hdl/gebin_ram.sv
// generic single write port ram with registered read
module gebin_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/grid_edge_binning.sv
// grid edge binning top level: sequencer, shared divider and cell counter rams
// count/place edge: three 32-step divisions and one read-modify-write per item
// read cell: one division, one ram read; activate: two divisions, then one ram read per column
// clear counters or marks: one cell per cycle through the ram
// one item at a time: the next input is taken in the cycle after the result transfer
// reset: async, then a clearing pass over every cell during which no item is taken
module grid_edge_binning import gebin_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic             clr_ctr_q, clr_ctr_d, clr_mark_q, clr_mark_d;
  logic             res_pend_q, res_pend_d;
  logic [CellW-1:0] clr_idx_q, clr_idx_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [31:0]      vc_q;
  logic [PartW-1:0] pc_q;

  in_t              item_q, item_d;
  logic [31:0]      a_q, a_d, d_q, d_d, r_q, r_d;
  logic [31:0]      base_q, base_d, split_q, split_d;
  logic [SideW-1:0] extra_q, extra_d, off_q, off_d;
  logic [SideW-1:0] row_q, row_d, col_q, col_d, i_q, i_d;
  logic [CellW-1:0] cell_q, cell_d, addr_q, addr_d;
  logic [6:0]       marked_q, marked_d;
  out_t             out_q, out_d;

  logic [31:0]      n_eff;
  logic [PartW-1:0] p_eff;
  logic [32:0]      rem_n, rem_sub;
  logic             rem_ge;
  logic [31:0]      vsel;
  logic [13:0]      pp;
  logic [12:0]      cell_prod;
  logic [63:0]      ctr_rd, ctr_wr;
  logic             ctr_we, mark_rd, mark_we, mark_wr;
  logic [CellW-1:0] wr_addr;
  logic [31:0]      total, fill;

  assign n_eff = (vc_q == 32'd0) ? 32'd1 : vc_q;
  assign p_eff = (pc_q == '0) ? PartW'(1) :
                 (pc_q > PartW'(MaxSide)) ? PartW'(MaxSide) : pc_q;
  assign pp        = 14'(p_eff) * 14'(p_eff);
  assign cell_prod = 13'(row_q) * 13'(p_eff) + 13'(col_q);

  assign rem_n   = {r_q, a_q[31]};
  assign rem_sub = rem_n - {1'b0, d_q};
  assign rem_ge  = rem_n >= {1'b0, d_q};

  assign vsel  = (phase_q == PH_DST) ? item_q.dest_vertex : item_q.src_vertex;
  assign total = ctr_rd[63:32];
  assign fill  = ctr_rd[31:0];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    clr_ctr_d  = clr_ctr_q;
    clr_mark_d = clr_mark_q;
    res_pend_d = res_pend_q;
    clr_idx_d  = clr_idx_q;
    cnt_d      = cnt_q;
    item_d     = item_q;
    a_d        = a_q;
    d_d        = d_q;
    r_d        = r_q;
    base_d     = base_q;
    split_d    = split_q;
    extra_d    = extra_q;
    off_d      = off_q;
    row_d      = row_q;
    col_d      = col_q;
    i_d        = i_q;
    cell_d     = cell_q;
    addr_d     = addr_q;
    marked_d   = marked_q;
    out_d      = out_q;
    ctr_we     = 1'b0;
    ctr_wr     = '0;
    mark_we    = 1'b0;
    mark_wr    = 1'b0;
    wr_addr    = addr_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          out_d  = '0;
          a_d    = n_eff;
          d_d    = 32'(p_eff);
          r_d    = '0;
          cnt_d  = '0;
          phase_d = PH_N;
          case (in_data_i.kind)
            KindCount, KindPlace: begin
              if (in_data_i.src_vertex >= n_eff || in_data_i.dest_vertex >= n_eff) begin
                out_d.status = StatVertex;
                state_d = S_OUT;
              end else begin
                state_d = S_DIV;
              end
            end
            KindActivate: begin
              if (in_data_i.src_vertex >= n_eff) begin
                out_d.status = StatVertex;
                state_d = S_OUT;
              end else begin
                state_d = S_DIV;
              end
            end
            KindRead: begin
              if ({2'b00, in_data_i.cell_index} >= pp) begin
                out_d.status = StatCell;
                state_d = S_OUT;
              end else begin
                a_d = 32'(in_data_i.cell_index);
                phase_d = PH_REQ;
                state_d = S_DIV;
              end
            end
            KindClrCtr: begin
              clr_ctr_d  = 1'b1;
              res_pend_d = 1'b1;
              clr_idx_d  = '0;
              state_d    = S_CLR;
            end
            KindClrMark: begin
              clr_mark_d = 1'b1;
              res_pend_d = 1'b1;
              clr_idx_d  = '0;
              state_d    = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        wr_addr = clr_idx_q;
        ctr_we  = clr_ctr_q;
        mark_we = clr_mark_q;
        clr_idx_d = clr_idx_q + CellW'(1);
        if (clr_idx_q == CellW'(Cells - 1)) begin
          clr_ctr_d  = 1'b0;
          clr_mark_d = 1'b0;
          res_pend_d = 1'b0;
          state_d    = res_pend_q ? S_OUT : S_IDLE;
        end
      end
      S_DIV: begin
        r_d   = rem_ge ? rem_sub[31:0] : rem_n[31:0];
        a_d   = {a_q[30:0], rem_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        case (phase_q)
          PH_N: begin
            base_d  = a_q;
            extra_d = r_q[SideW-1:0];
            split_d = 32'(r_q[SideW-1:0] * (33'(a_q) + 33'd1));
            phase_d = PH_SRC;
            state_d = S_VSEL;
          end
          PH_SRC: begin
            row_d = a_q[SideW-1:0] + off_q;
            if (item_q.kind == KindActivate) begin
              col_d   = '0;
              state_d = S_CELL;
            end else begin
              phase_d = PH_DST;
              state_d = S_VSEL;
            end
          end
          PH_DST: begin
            col_d   = a_q[SideW-1:0] + off_q;
            state_d = S_CELL;
          end
          default: begin
            row_d   = a_q[SideW-1:0];
            col_d   = r_q[SideW-1:0];
            cell_d  = item_q.cell_index;
            addr_d  = item_q.cell_index;
            state_d = S_RD;
          end
        endcase
      end
      S_VSEL: begin
        r_d   = '0;
        cnt_d = '0;
        if (extra_q == '0) begin
          a_d = vsel;
          d_d = base_q;
          off_d = '0;
        end else if (vsel < split_q) begin
          a_d = vsel;
          d_d = base_q + 32'd1;
          off_d = '0;
        end else begin
          a_d = vsel - split_q;
          d_d = base_q;
          off_d = extra_q;
        end
        state_d = S_DIV;
      end
      S_CELL: begin
        cell_d   = cell_prod[CellW-1:0];
        addr_d   = cell_prod[CellW-1:0];
        i_d      = '0;
        marked_d = '0;
        state_d  = (item_q.kind == KindActivate) ? S_ACTRD : S_RD;
      end
      S_RD: begin
        state_d = S_RMW;
      end
      S_RMW: begin
        out_d.status      = StatOk;
        out_d.row_part    = row_q;
        out_d.col_part    = col_q;
        out_d.cell_out    = cell_q;
        out_d.cell_total  = total;
        out_d.cell_active = mark_rd;
        case (item_q.kind)
          KindCount: begin
            if (total == '1) begin
              out_d.status = StatOverflow;
            end else begin
              ctr_we = 1'b1;
              ctr_wr = {total + 32'd1, fill};
              out_d.cell_total = total + 32'd1;
            end
          end
          KindPlace: begin
            if (fill >= total) begin
              out_d.status = StatOverflow;
            end else begin
              ctr_we = 1'b1;
              ctr_wr = {total, fill + 32'd1};
              out_d.slot = fill;
            end
          end
          default: begin
            out_d.slot = fill;
          end
        endcase
        state_d = S_OUT;
      end
      S_ACTRD: begin
        state_d = S_ACTCHK;
      end
      S_ACTCHK: begin
        if (total != 32'd0) begin
          mark_we  = 1'b1;
          mark_wr  = 1'b1;
          marked_d = marked_q + 7'd1;
        end
        if ((PartW'(i_q) + PartW'(1)) == p_eff) begin
          out_d.status       = StatOk;
          out_d.row_part     = row_q;
          out_d.cell_out     = cell_q;
          out_d.marked_cells = (total != 32'd0) ? marked_q + 7'd1 : marked_q;
          state_d = S_OUT;
        end else begin
          i_d     = i_q + SideW'(1);
          addr_d  = addr_q + CellW'(1);
          state_d = S_ACTRD;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      phase_q    <= PH_N;
      clr_ctr_q  <= 1'b1;
      clr_mark_q <= 1'b1;
      res_pend_q <= 1'b0;
      clr_idx_q  <= '0;
      cnt_q      <= '0;
      vc_q       <= 32'd1;
      pc_q       <= PartW'(4);
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      clr_ctr_q  <= clr_ctr_d;
      clr_mark_q <= clr_mark_d;
      res_pend_q <= res_pend_d;
      clr_idx_q  <= clr_idx_d;
      cnt_q      <= cnt_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgVertexCount) begin
          vc_q <= cfg_data_i;
        end else begin
          pc_q <= cfg_data_i[PartW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    a_q      <= a_d;
    d_q      <= d_d;
    r_q      <= r_d;
    base_q   <= base_d;
    split_q  <= split_d;
    extra_q  <= extra_d;
    off_q    <= off_d;
    row_q    <= row_d;
    col_q    <= col_d;
    i_q      <= i_d;
    cell_q   <= cell_d;
    addr_q   <= addr_d;
    marked_q <= marked_d;
    out_q    <= out_d;
  end

  gebin_ram #(.Width(64), .Depth(Cells)) u_ctr_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ctr_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (ctr_wr),
    .rd_addr_i (addr_q),
    .rd_data_o (ctr_rd)
  );

  gebin_ram #(.Width(1), .Depth(Cells)) u_mark_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mark_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (mark_wr),
    .rd_addr_i (addr_q),
    .rd_data_o (mark_rd)
  );

endmodule
